// File: hdl/rvvt_pkg.sv
package rvvt_pkg;

    // Table geometry
    localparam int ROW_COUNT = 1024;
    localparam int ADDR_W    = $clog2(ROW_COUNT);
    localparam int CNT_W     = $clog2(ROW_COUNT + 1);

    // Field widths
    localparam int FUNC_W = 3;
    localparam int ROW_W  = 10;
    localparam int TX_W   = 32;
    localparam int TIME_W = 32;
    localparam int KIND_W = 2;

    // Row compare width: wide enough for both the row field and the table index
    localparam int ROW_EXT_W = ((ADDR_W > ROW_W) ? ADDR_W : ROW_W) + 1;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_MARK_DELETE = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_MARK_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_MARK_UPDATE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_COMMIT      = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR       = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_QUERY       = 3'd5;

    // Marker kinds (a mark stores the low bits of its function code)
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ROW_W-1:0]  row;
        logic [TX_W-1:0]   tx_id;
        logic [TIME_W-1:0] time_value;
    } in_item_t;

    typedef struct packed {
        logic visible;
        logic entry_present;
        logic any_uncommitted;
    } out_item_t;

    // One table word per row
    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [TX_W-1:0]   owner;
        logic              committed;
        logic [TIME_W-1:0] commit_stamp;
    } entry_t;

    // Table write request
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
    } ram_wr_t;

    // Post-reset clearing sweep status
    typedef struct packed {
        logic              active;
        logic [ADDR_W-1:0] addr;
    } clr_ctl_t;

    function automatic logic row_in_range(input logic [ROW_W-1:0] row);
        logic [ROW_EXT_W-1:0] ext;
        ext = ROW_EXT_W'(row);
        return ext < ROW_EXT_W'(ROW_COUNT);
    endfunction

    function automatic logic [ADDR_W-1:0] row_addr(input logic [ROW_W-1:0] row);
        logic [ROW_EXT_W-1:0] ext;
        ext = ROW_EXT_W'(row);
        return ext[ADDR_W-1:0];
    endfunction

endpackage

// File: hdl/rvvt_ram.sv
module rvvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/rvvt_init.sv
module rvvt_init (
    input  logic              clk,
    input  logic              rst_n,
    output rvvt_pkg::clr_ctl_t clr
);
    import rvvt_pkg::*;

    logic              active_reg;
    logic              active_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;

    // Sweep every row once after reset, one row per cycle
    always_comb
    begin
        active_next = active_reg;
        addr_next   = addr_reg;
        if (active_reg)
        begin
            addr_next = addr_reg + ADDR_W'(1);
            if (addr_reg == ADDR_W'(ROW_COUNT - 1))
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            addr_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            addr_reg   <= addr_next;
        end
    end

    assign clr.active = active_reg;
    assign clr.addr   = addr_reg;

endmodule

// File: hdl/rvvt_exec.sv
module rvvt_exec (
    input  rvvt_pkg::in_item_t             item,
    input  rvvt_pkg::entry_t               entry,
    input  logic [rvvt_pkg::CNT_W-1:0]     cnt,
    output rvvt_pkg::ram_wr_t              wr,
    output rvvt_pkg::out_item_t            result,
    output logic [rvvt_pkg::CNT_W-1:0]     cnt_next
);
    import rvvt_pkg::*;

    logic in_range;
    logic present;
    logic is_mark;
    logic own;
    logic older;
    logic dec_ok;
    logic vis;
    logic rule_vis;

    // Visibility rules for a present marker
    always_comb
    begin
        own   = (entry.owner == item.tx_id);
        older = entry.committed && (entry.commit_stamp < item.time_value);
        case (entry.kind)
            KIND_DELETE: rule_vis = own ? 1'b0 : (!entry.committed ? 1'b1 : !older);
            KIND_INSERT,
            KIND_UPDATE: rule_vis = own ? 1'b1 : older;
            default:     rule_vis = 1'b1;
        endcase
    end

    // Marker, commit and clear updates, query visibility and uncommitted count
    always_comb
    begin
        in_range   = row_in_range(item.row);
        present    = in_range && entry.valid;
        is_mark    = item.func inside {FUNC_MARK_DELETE, FUNC_MARK_INSERT, FUNC_MARK_UPDATE};
        dec_ok     = !entry.committed && (cnt != '0);
        wr.wr_en   = 1'b0;
        wr.wr_addr = row_addr(item.row);
        wr.wr_data = entry;
        cnt_next   = cnt;
        vis        = 1'b0;

        if (is_mark)
        begin
            if (in_range)
            begin
                wr.wr_en = 1'b1;
                if (!present || entry.committed)
                begin
                    cnt_next = cnt + CNT_W'(1);
                end
                wr.wr_data.valid     = 1'b1;
                wr.wr_data.kind      = item.func[KIND_W-1:0];
                wr.wr_data.owner     = item.tx_id;
                wr.wr_data.committed = 1'b0;
            end
        end
        else
        begin
            case (item.func)
                FUNC_COMMIT:
                begin
                    if (present)
                    begin
                        wr.wr_en = 1'b1;
                        if (dec_ok)
                        begin
                            cnt_next = cnt - CNT_W'(1);
                        end
                        wr.wr_data.committed    = 1'b1;
                        wr.wr_data.commit_stamp = item.time_value;
                    end
                end
                FUNC_CLEAR:
                begin
                    if (present)
                    begin
                        wr.wr_en = 1'b1;
                        if (dec_ok)
                        begin
                            cnt_next = cnt - CNT_W'(1);
                        end
                        wr.wr_data.valid = 1'b0;
                    end
                end
                FUNC_QUERY:
                begin
                    vis = present ? rule_vis : 1'b1;
                end
                default:
                begin
                    vis = 1'b0;
                end
            endcase
        end

        result.visible         = vis;
        result.entry_present   = present;
        result.any_uncommitted = (cnt_next != '0);
    end

endmodule

// File: hdl/row_version_visibility_table_core.sv
// Row version visibility table core.
// Input channel (in_valid/in_ready/in_item) carries one operation per transfer:
// mark delete/insert/update, commit, clear or visibility query on one row.
// Output channel (out_valid/out_ready/out_item) returns exactly one result per
// input transfer, in order: visible, entry_present and any_uncommitted.
// Timing: the table read and the item are registered at the input transfer;
// the evaluate stage then writes back and loads the result register, which
// drives out_valid. Throughput: one item per cycle while the output drains;
// the table is one 1024-row RAM with one write and one registered read port,
// and a write-back bypass covers back-to-back items on the same row.
// Reset: asynchronous, active low. After reset the table is swept once to
// clear every marker, one row per cycle over all ROW_COUNT (1024) rows;
// in_ready stays low during the sweep.
// Stall: when out_ready is low the result register holds, one more item can
// sit in the evaluate stage, and then in_ready drops until the output drains.
module row_version_visibility_table_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rvvt_pkg::in_item_t    in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rvvt_pkg::out_item_t   out_item
);
    import rvvt_pkg::*;

    clr_ctl_t          clr;
    logic              accept;
    logic              s1_fire;

    // Evaluate stage
    logic              s1_valid_reg;
    in_item_t          s1_item_reg;
    logic              fwd_hit_reg;
    entry_t            fwd_data_reg;
    entry_t            ram_rdata;
    entry_t            s1_entry;

    // Counter and result
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    ram_wr_t           ex_wr;
    out_item_t         ex_result;
    logic              out_valid_reg;
    out_item_t         out_item_reg;

    // Table write port
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    entry_t            ram_wr_data;
    logic              item_wr;

    rvvt_init u_init (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (clr)
    );

    // Handshake
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clr.active && (!s1_valid_reg || s1_fire);
    assign accept   = in_valid && in_ready;
    assign item_wr  = s1_fire && ex_wr.wr_en;

    // Write mux: clearing sweep owns the port until done
    always_comb
    begin
        if (clr.active)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr.addr;
            ram_wr_data = '0;
        end
        else
        begin
            ram_wr_en   = item_wr;
            ram_wr_addr = ex_wr.wr_addr;
            ram_wr_data = ex_wr.wr_data;
        end
    end

    rvvt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ROW_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (row_addr(in_item.row)),
        .rd_data (ram_rdata)
    );

    // Bypass the write that lands on the same edge as this item's read
    assign s1_entry = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    rvvt_exec u_exec (
        .item     (s1_item_reg),
        .entry    (s1_entry),
        .cnt      (cnt_reg),
        .wr       (ex_wr),
        .result   (ex_result),
        .cnt_next (cnt_next)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= item_wr && row_in_range(in_item.row)
                                && (ex_wr.wr_addr == row_addr(in_item.row));
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
                cnt_reg       <= cnt_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
        end
        if (item_wr)
        begin
            fwd_data_reg <= ex_wr.wr_data;
        end
        if (s1_fire)
        begin
            out_item_reg <= ex_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ROW_COUNT))
        else $error("uncommitted count exceeds row count");

    a_no_item_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr.active |-> !s1_valid_reg)
        else $error("item in flight during clearing sweep");

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("evaluated item produced no result");

    a_any_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> (out_item_reg.any_uncommitted == (cnt_reg != '0)))
        else $error("any_uncommitted disagrees with count");

endmodule
